FILE: sv/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types and constants of the magnetometer min/max calibration block.
// ----------------------------------------------------------------------------
package mmc_pkg;

  // result field widths
  localparam int TOTAL_W  = 20;
  localparam int OFFSET_W = 15;
  localparam int SCALE_W  = 16;
  localparam int FIELD_W  = 16;

  // configuration register widths
  localparam int WARN_W   = 15;
  localparam int MARGIN_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WARN_RANGE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MIN_RANGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MARGIN    = 2'd2;

  // register reset values
  localparam logic [WARN_W-1:0]   WARN_RESET   = 15'd200;
  localparam logic [WARN_W-1:0]   SMR_RESET    = 15'd100;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd500;

  // extremes after reset, 1000.0 uT in 0.1 uT units
  localparam int MIN_RESET = 10000;
  localparam int MAX_RESET = -10000;

  // scale is unsigned Q4.12
  localparam int SCALE_FRAC = 12;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;
  localparam logic [SCALE_W-1:0] SCALE_SAT = 16'hFFFF;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic  sample_en;
    logic  div_start;
    axis_t div_axis;
    logic  load_out;
    axis_t axis;
    logic  clear;
  } mmc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } mmc_stat_t;

endpackage

FILE: sv/mmc_div.sv
// ----------------------------------------------------------------------------
// mmc_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmc_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  // one shift and trial subtract per cycle
  always_comb begin
    rem_sh   = {rem_r, nq_r[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nq_nxt   = nq_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      den_nxt = den;
      nq_nxt  = num;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nq_nxt   = {nq_r[NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nq_r  <= nq_nxt;
  end

  assign quo  = nq_r;
  assign done = done_r;

endmodule

FILE: sv/mmc_datapath.sv
// ----------------------------------------------------------------------------
// mmc_datapath
// Min/max tracking, sample count, configuration registers, per-axis result
// arithmetic, scale divider and registered result ports.
// ----------------------------------------------------------------------------
module mmc_datapath #(
  parameter int SAMPLE_WIDTH = 14,
  parameter int COUNT_WIDTH  = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_mag_x,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_mag_y,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_mag_z,
  input  logic                                 cfg_we,
  input  logic [mmc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  mmc_pkg::mmc_cmd_t                    cmd,
  output mmc_pkg::mmc_stat_t                   stat,
  output logic                                 out_valid,
  output logic [1:0]                           out_axis,
  output logic signed [mmc_pkg::OFFSET_W-1:0]  out_offset,
  output logic [mmc_pkg::SCALE_W-1:0]          out_scale,
  output logic signed [mmc_pkg::FIELD_W-1:0]   out_span,
  output logic signed [mmc_pkg::FIELD_W-1:0]   out_bound_low,
  output logic signed [mmc_pkg::FIELD_W-1:0]   out_bound_high,
  output logic                                 out_limited_rotation,
  output logic [mmc_pkg::TOTAL_W-1:0]          out_sample_total,
  output logic                                 out_last
);

  import mmc_pkg::*;

  // extreme registers must hold the reset extremes and any sample
  localparam int EXT_W  = (SAMPLE_WIDTH > 15) ? SAMPLE_WIDTH : 15;
  localparam int SPW    = EXT_W + 1;
  localparam int SUMW   = SPW + 2;
  localparam int NUM_W  = SUMW + SCALE_FRAC;
  localparam int DEN_W  = SPW + 2;
  localparam int BND_W  = SPW + 1;

  localparam logic signed [EXT_W-1:0] MIN_INIT = EXT_W'(MIN_RESET);
  localparam logic signed [EXT_W-1:0] MAX_INIT = EXT_W'(MAX_RESET);

  // configuration registers
  logic [WARN_W-1:0]   warn_r, warn_nxt;
  logic [WARN_W-1:0]   smr_r, smr_nxt;
  logic [MARGIN_W-1:0] margin_r, margin_nxt;

  // run state
  logic signed [EXT_W-1:0] mn_r [3];
  logic signed [EXT_W-1:0] mx_r [3];
  logic signed [EXT_W-1:0] mn_nxt [3];
  logic signed [EXT_W-1:0] mx_nxt [3];
  logic signed [EXT_W-1:0] smp [3];
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;

  // per-axis arithmetic
  logic signed [SPW-1:0]   sp [3];
  logic signed [SPW-1:0]   mid [3];
  logic signed [BND_W-1:0] blo [3];
  logic signed [BND_W-1:0] bhi [3];
  logic signed [SUMW-1:0]  sum;
  logic signed [SPW:0]     warn_s;
  logic signed [SPW-1:0]   smr_s;
  logic signed [BND_W-1:0] margin_s;
  logic                    lim;
  logic [TOTAL_W-1:0]      total;

  // divider operands and result
  logic [SPW-1:0]   den_span;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic             div_done;
  logic [SCALE_W-1:0] scale_sel;
  logic signed [SPW-1:0] span_sel;

  // result registers
  logic                        ov_r, ov_nxt;
  axis_t                       oaxis_r;
  logic signed [OFFSET_W-1:0]  ooff_r;
  logic [SCALE_W-1:0]          oscale_r;
  logic signed [FIELD_W-1:0]   ospan_r;
  logic signed [FIELD_W-1:0]   oblo_r;
  logic signed [FIELD_W-1:0]   obhi_r;
  logic                        olim_r;
  logic [TOTAL_W-1:0]          ototal_r;
  logic                        olast_r;

  // configuration writes
  always_comb begin
    warn_nxt   = warn_r;
    smr_nxt    = smr_r;
    margin_nxt = margin_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WARN_RANGE:      warn_nxt   = cfg_data[WARN_W-1:0];
        REG_SCALE_MIN_RANGE: smr_nxt    = cfg_data[WARN_W-1:0];
        REG_BOUND_MARGIN:    margin_nxt = cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r   <= WARN_RESET;
      smr_r    <= SMR_RESET;
      margin_r <= MARGIN_RESET;
    end else begin
      warn_r   <= warn_nxt;
      smr_r    <= smr_nxt;
      margin_r <= margin_nxt;
    end
  end

  // min/max tracking and saturating sample count
  assign smp[0] = EXT_W'(in_mag_x);
  assign smp[1] = EXT_W'(in_mag_y);
  assign smp[2] = EXT_W'(in_mag_z);

  always_comb begin
    cnt_nxt = cnt_r;
    for (int k = 0; k < 3; k++) begin
      mn_nxt[k] = mn_r[k];
      mx_nxt[k] = mx_r[k];
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
      for (int k = 0; k < 3; k++) begin
        mn_nxt[k] = MIN_INIT;
        mx_nxt[k] = MAX_INIT;
      end
    end else if (cmd.sample_en) begin
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + COUNT_WIDTH'(1);
      end
      for (int k = 0; k < 3; k++) begin
        if (smp[k] < mn_r[k]) mn_nxt[k] = smp[k];
        if (smp[k] > mx_r[k]) mx_nxt[k] = smp[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) begin
        mn_r[k] <= MIN_INIT;
        mx_r[k] <= MAX_INIT;
      end
    end else begin
      cnt_r <= cnt_nxt;
      for (int k = 0; k < 3; k++) begin
        mn_r[k] <= mn_nxt[k];
        mx_r[k] <= mx_nxt[k];
      end
    end
  end

  // span, midpoint and bounds of every axis
  assign margin_s = BND_W'($signed({1'b0, margin_r}));
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sp[k]  = SPW'(mx_r[k]) - SPW'(mn_r[k]);
      mid[k] = SPW'(mx_r[k]) + SPW'(mn_r[k]);
      blo[k] = BND_W'(mn_r[k]) - margin_s;
      bhi[k] = BND_W'(mx_r[k]) + margin_s;
    end
  end

  assign sum    = SUMW'(sp[0]) + SUMW'(sp[1]) + SUMW'(sp[2]);
  assign warn_s = (SPW + 1)'($signed({1'b0, warn_r}));
  assign smr_s  = SPW'($signed({1'b0, smr_r}));
  assign lim    = ((SPW + 1)'(sp[0]) < warn_s) || ((SPW + 1)'(sp[1]) < warn_s);

  // saturated count for the result field
  generate
    if (COUNT_WIDTH > TOTAL_W) begin : g_total_sat
      assign total = (cnt_r[COUNT_WIDTH-1:TOTAL_W] != '0) ? '1 : cnt_r[TOTAL_W-1:0];
    end else begin : g_total_ext
      assign total = TOTAL_W'(cnt_r);
    end
  endgenerate

  // divider: sum * 4096 over 3 * span
  assign den_span = sp[cmd.div_axis];
  assign den      = (DEN_W'(den_span) << 1) + DEN_W'(den_span);
  assign num      = {sum, {SCALE_FRAC{1'b0}}};

  mmc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

  assign stat.div_done = div_done;

  // scale selection for the axis being emitted
  assign span_sel = sp[cmd.axis];
  always_comb begin
    priority if (span_sel <= smr_s) begin
      scale_sel = SCALE_ONE;
    end else if (sum <= '0) begin
      scale_sel = '0;
    end else if (quo[NUM_W-1:SCALE_W] != '0) begin
      scale_sel = SCALE_SAT;
    end else begin
      scale_sel = quo[SCALE_W-1:0];
    end
  end

  // result strobe
  assign ov_nxt = cmd.load_out;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      oaxis_r  <= cmd.axis;
      ooff_r   <= OFFSET_W'(mid[cmd.axis] >>> 1);
      oscale_r <= scale_sel;
      ospan_r  <= span_sel[FIELD_W-1:0];
      oblo_r   <= blo[cmd.axis][FIELD_W-1:0];
      obhi_r   <= bhi[cmd.axis][FIELD_W-1:0];
      olim_r   <= lim;
      ototal_r <= total;
      olast_r  <= (cmd.axis == AXIS_Z);
    end
  end

  assign out_valid            = ov_r;
  assign out_axis             = oaxis_r;
  assign out_offset           = ooff_r;
  assign out_scale            = oscale_r;
  assign out_span             = ospan_r;
  assign out_bound_low        = oblo_r;
  assign out_bound_high       = obhi_r;
  assign out_limited_rotation = olim_r;
  assign out_sample_total     = ototal_r;
  assign out_last             = olast_r;

  // a load always produces one strobe
  a_load_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result load without strobe");

  // the closing result is the Z axis
  a_last_is_z: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_axis == AXIS_Z))
    else $error("last flag on a non-Z result");

  // a finished run starts from an empty count
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (cnt_r == '0))
    else $error("count not cleared after finish");

endmodule

FILE: sv/mmc_ctrl.sv
// ----------------------------------------------------------------------------
// mmc_ctrl
// Controller: takes commands, steps the three per-axis divisions on finish
// and issues result loads and the state clear.
// ----------------------------------------------------------------------------
module mmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_command,
  input  mmc_pkg::mmc_stat_t  stat,
  output logic                busy,
  output mmc_pkg::mmc_cmd_t   cmd
);

  import mmc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  axis_t  axis_r, axis_nxt;
  logic   accept;
  logic   step_done;

  assign accept    = start && (state_r == ST_IDLE);
  assign step_done = (state_r == ST_DIV) && stat.div_done;

  // next state and axis
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_command) begin
          state_nxt = ST_DIV;
          axis_nxt  = AXIS_X;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          if (axis_r == AXIS_Z) begin
            state_nxt = ST_IDLE;
            axis_nxt  = AXIS_X;
          end else begin
            axis_nxt = axis_r + axis_t'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        axis_nxt  = AXIS_X;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd.sample_en = accept && !in_command;
    cmd.div_start = (accept && in_command) || (step_done && (axis_r != AXIS_Z));
    cmd.div_axis  = accept ? AXIS_X : (axis_r + axis_t'(1));
    cmd.load_out  = step_done;
    cmd.axis      = axis_r;
    cmd.clear     = step_done && (axis_r == AXIS_Z);
  end

  assign busy = (state_r == ST_DIV);

endmodule

FILE: sv/magnetometer_minmax_calibration.sv
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration
// A sample command can be issued every cycle while busy is low; busy stays low.
// A finish command raises busy while one radix-2 divider computes the scale
// of each axis in turn, one quotient bit per cycle.
// The three results strobe out_valid at the end of each axis division.
// Synchronous active-low reset restores the configuration registers and clears the run state.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration #(
  parameter int SAMPLE_WIDTH = 14,
  parameter int COUNT_WIDTH  = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_mag_x,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_mag_y,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_mag_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mmc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  output logic [1:0]                           out_axis,
  output logic signed [mmc_pkg::OFFSET_W-1:0]  out_offset,
  output logic [mmc_pkg::SCALE_W-1:0]          out_scale,
  output logic signed [mmc_pkg::FIELD_W-1:0]   out_span,
  output logic signed [mmc_pkg::FIELD_W-1:0]   out_bound_low,
  output logic signed [mmc_pkg::FIELD_W-1:0]   out_bound_high,
  output logic                                 out_limited_rotation,
  output logic [mmc_pkg::TOTAL_W-1:0]          out_sample_total,
  output logic                                 out_last
);

  import mmc_pkg::*;

  mmc_cmd_t  cmd;
  mmc_stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  mmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  mmc_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_mag_x             (in_mag_x),
    .in_mag_y             (in_mag_y),
    .in_mag_z             (in_mag_z),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_axis             (out_axis),
    .out_offset           (out_offset),
    .out_scale            (out_scale),
    .out_span             (out_span),
    .out_bound_low        (out_bound_low),
    .out_bound_high       (out_bound_high),
    .out_limited_rotation (out_limited_rotation),
    .out_sample_total     (out_sample_total),
    .out_last             (out_last)
  );

endmodule
